// ----- src/sha256sh_pkg.sv -----
// Shared types, constants and round functions for the streaming SHA-256 hasher.
`timescale 1ns / 1ps

package sha256sh_pkg;

  // Largest byte count a message may reach (2^61 - 1).
  localparam logic [60:0] ByteTotalMax = {61{1'b1}};
  localparam logic [7:0]  PadByte      = 8'h80;
  // Last byte position before the 64-bit length field.
  localparam logic [5:0]  LastPadPos   = 6'd55;
  localparam logic [5:0]  LastBytePos  = 6'd63;
  localparam logic [5:0]  LastRound    = 6'd63;
  localparam logic [2:0]  LastWord     = 3'd7;

  // One message item as it arrives.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;
  } in_item_t;

  // One digest word as it leaves.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_error;
  } out_item_t;

  // Source of a byte written into the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;
    byte_src_t  wr_sel;
    logic [5:0] wr_pos;
    logic       count_en;
    logic       ovf_set;
    logic       load_len;
    logic       init_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_add;
    logic       emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       at_max;
    logic       overflow;
    logic       out_busy;
  } dp_status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // Initial hash value for each chaining word.
  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6A09E667;
      3'd1:    init_hash = 32'hBB67AE85;
      3'd2:    init_hash = 32'h3C6EF372;
      3'd3:    init_hash = 32'hA54FF53A;
      3'd4:    init_hash = 32'h510E527F;
      3'd5:    init_hash = 32'h9B05688C;
      3'd6:    init_hash = 32'h1F83D9AB;
      default: init_hash = 32'h5BE0CD19;
    endcase
  endfunction

  // Round constant table.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
      6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
      6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
      6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
      6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
      6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
      6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
      6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
      6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
      6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
      6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
      6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
      6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
      6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
      6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
      6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
      6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
      6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
      6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
      6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
      6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
      6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
      6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
      6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
      6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
      6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
      6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
      6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
      6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
      6'd62: round_k = 32'hBEF9A3F7;  default: round_k = 32'hC67178F2;
    endcase
  endfunction

endpackage

// ----- src/sha256sh_datapath.sv -----
// Datapath: block buffer and schedule window, round logic, chaining state and digest buffer.
`timescale 1ns / 1ps

module sha256sh_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  sha256sh_pkg::ctrl_cmd_t  cmd,
  input  logic [7:0]               data_byte,
  output sha256sh_pkg::dp_status_t status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sha256sh_pkg::out_item_t  out_item
);

  // Block words double as the rolling message schedule.
  logic [31:0] win [16];
  logic [31:0] wv [8];
  logic [31:0] chain [8];
  logic [60:0] byte_total;
  logic        overflow;

  // Digest buffer, drained one word per transfer.
  logic [31:0] obuf [8];
  logic [2:0]  out_idx;
  logic        out_err;

  logic [7:0]  wr_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_next;
  logic [63:0] bit_len;
  logic        out_xfer;

  // Byte source selection.
  always_comb begin
    case (cmd.wr_sel)
      sha256sh_pkg::SRC_DATA: wr_byte = data_byte;
      sha256sh_pkg::SRC_PAD:  wr_byte = sha256sh_pkg::PadByte;
      default:                wr_byte = 8'h00;
    endcase
  end

  // One compression round and the next schedule word.
  always_comb begin
    t1 = wv[7] + sha256sh_pkg::big_sigma1(wv[4]) +
         sha256sh_pkg::choose(wv[4], wv[5], wv[6]) +
         sha256sh_pkg::round_k(cmd.round_idx) + win[0];
    t2 = sha256sh_pkg::big_sigma0(wv[0]) + sha256sh_pkg::majority(wv[0], wv[1], wv[2]);
    w_next = sha256sh_pkg::small_sigma1(win[14]) + win[9] +
             sha256sh_pkg::small_sigma0(win[1]) + win[0];
  end

  assign bit_len  = {byte_total, 3'b000};
  assign out_xfer = out_valid && !out_stall;

  // Block buffer and schedule window.
  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_next;
    end else if (cmd.load_len) begin
      win[14] <= bit_len[63:32];
      win[15] <= bit_len[31:0];
    end else if (cmd.wr_en) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (cmd.wr_pos[5:2] == 4'(i) && cmd.wr_pos[1:0] == 2'(3 - j)) begin
            win[i][8*j +: 8] <= wr_byte;
          end
        end
      end
    end
  end

  // Working variables a to h.
  always_ff @(posedge clk) begin
    if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // Chaining state, byte count and length flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256sh_pkg::init_hash(3'(i));
      end
      byte_total <= '0;
      overflow   <= 1'b0;
    end else begin
      if (cmd.chain_add) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end
      if (cmd.count_en) begin
        byte_total <= byte_total + 61'd1;
      end
      if (cmd.ovf_set) begin
        overflow <= 1'b1;
      end
    end
  end

  // Digest buffer payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int i = 0; i < 8; i++) begin
        obuf[i] <= chain[i];
      end
      out_err <= overflow;
    end else if (out_xfer) begin
      for (int i = 0; i < 7; i++) begin
        obuf[i] <= obuf[i + 1];
      end
      obuf[7] <= obuf[7];
    end
  end

  // Digest buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      out_idx   <= '0;
    end else if (out_xfer) begin
      out_idx <= out_idx + 3'd1;
      if (out_idx == sha256sh_pkg::LastWord) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_item.digest_word  = obuf[0];
  assign out_item.word_index   = out_idx;
  assign out_item.last_word    = (out_idx == sha256sh_pkg::LastWord);
  assign out_item.length_error = out_err;

  assign status.fill     = byte_total[5:0];
  assign status.at_max   = (byte_total == sha256sh_pkg::ByteTotalMax);
  assign status.overflow = overflow;
  assign status.out_busy = out_valid;

endmodule

// ----- src/sha256sh_ctrl.sv -----
// Controller: sequences byte intake, padding, compression rounds and digest hand-off.
`timescale 1ns / 1ps

module sha256sh_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     msg_valid,
  output logic                     msg_stall,
  input  logic                     byte_valid,
  input  logic                     last_item,
  input  sha256sh_pkg::dp_status_t status,
  output sha256sh_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_WAIT_OUT
  } state_t;

  state_t     state;
  logic [5:0] round;
  logic [5:0] pad_pos;
  logic       pad_first;
  logic       finishing;
  logic       final_blk;

  logic       accept;
  logic       wrote;
  logic       block_full;

  assign msg_stall  = (state != ST_IDLE);
  assign accept     = msg_valid && (state == ST_IDLE);
  assign wrote      = byte_valid && !status.at_max;
  assign block_full = wrote && (status.fill == sha256sh_pkg::LastBytePos);

  // Command decode from the current state.
  always_comb begin
    cmd           = '0;
    cmd.wr_sel    = sha256sh_pkg::SRC_DATA;
    cmd.round_idx = round;
    unique case (state)
      ST_IDLE: begin
        cmd.wr_en    = accept && wrote;
        cmd.wr_pos   = status.fill;
        cmd.count_en = accept && wrote;
        cmd.ovf_set  = accept && byte_valid && status.at_max;
      end
      ST_PAD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pad_first ? sha256sh_pkg::SRC_PAD : sha256sh_pkg::SRC_ZERO;
        cmd.wr_pos = pad_pos;
      end
      ST_LEN:      cmd.load_len  = 1'b1;
      ST_INIT:     cmd.init_vars = 1'b1;
      ST_ROUND:    cmd.round_en  = 1'b1;
      ST_ADD:      cmd.chain_add = 1'b1;
      ST_WAIT_OUT: cmd.emit      = !status.out_busy;
      default:     cmd = '0;
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round     <= '0;
      pad_pos   <= '0;
      pad_first <= 1'b0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (block_full) begin
              // Full block first; padding starts afresh at byte zero.
              state     <= ST_INIT;
              finishing <= last_item;
              pad_pos   <= '0;
              pad_first <= 1'b1;
            end else if (last_item) begin
              state     <= ST_PAD;
              finishing <= 1'b1;
              pad_pos   <= status.fill + {5'd0, wrote};
              pad_first <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          pad_pos   <= pad_pos + 6'd1;
          if (pad_pos == sha256sh_pkg::LastPadPos) begin
            state <= ST_LEN;
          end else if (pad_pos == sha256sh_pkg::LastBytePos) begin
            // No room for the length: compress this block and pad another.
            state <= ST_INIT;
          end
        end
        ST_LEN: begin
          final_blk <= 1'b1;
          state     <= ST_INIT;
        end
        ST_INIT: begin
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == sha256sh_pkg::LastRound) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (final_blk) begin
            state <= ST_WAIT_OUT;
          end else if (finishing) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_WAIT_OUT: begin
          if (!status.out_busy) begin
            state     <= ST_IDLE;
            finishing <= 1'b0;
            final_blk <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sha256_stream_hasher.sv -----
// Top level of the streaming SHA-256 hasher: one message byte per transfer in, digest words out.
// Bytes are taken one per cycle while input is not stalled; a block's 64th byte stalls input
// during compression. A last item pads one byte per cycle to position 55, writes the length and
// compresses once or twice; the digest then leaves as eight word transfers.
// Synchronous reset restores the initial hash values, clears the byte count and flags and empties the buffer.
`timescale 1ns / 1ps

module sha256_stream_hasher (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    msg_valid,
  output logic                    msg_stall,
  input  sha256sh_pkg::in_item_t  msg,
  output logic                    dgst_valid,
  input  logic                    dgst_stall,
  output sha256sh_pkg::out_item_t dgst
);

  sha256sh_pkg::ctrl_cmd_t  cmd;
  sha256sh_pkg::dp_status_t status;

  // Controller.
  sha256sh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .byte_valid (msg.byte_valid),
    .last_item  (msg.last_item),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath.
  sha256sh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (msg.data_byte),
    .status    (status),
    .out_valid (dgst_valid),
    .out_stall (dgst_stall),
    .out_item  (dgst)
  );

`ifndef SYNTH
  // A new digest is never loaded over one still draining.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("digest emitted while output buffer busy");

  // The length flag is only raised once the count has saturated.
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    status.overflow |-> status.at_max)
    else $error("length flag set below saturation");

  // Digest words leave in order without a gap inside a digest.
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    dgst_valid && !dgst_stall && !dgst.last_word |=>
      dgst_valid && dgst.word_index == $past(dgst.word_index) + 3'd1)
    else $error("digest word order broken");
`endif

endmodule

// ----- tb/tb_sha256_stream_hasher.sv -----
// Self-checking testbench for the streaming SHA-256 hasher, with its own digest predictor.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

  // Stimulus sizes and run limits.
  localparam int TotalItems  = 320;
  localparam int DrainCycles = 200;
  localparam int SideSend    = 0;
  localparam int SideRecv    = 1;

  // Well-known digests of the empty message and of "abc".
  localparam logic [255:0] EmptyDigest =
    256'hE3B0C442_98FC1C14_9AFBF4C8_996FB924_27AE41E4_649B934C_A495991B_7852B855;
  localparam logic [255:0] AbcDigest =
    256'hBA7816BF_8F01CFEA_414140DE_5DAE2223_B00361A3_96177A9C_B410FF61_F20015AD;

  localparam logic [31:0] InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // One row of the directed table: the item and, where it is known, the digest it ends with.
  typedef struct packed {
    sha256sh_pkg::in_item_t item;
    logic                   known;
    logic [255:0]           dgst;
  } stim_row_t;

  localparam int DirectedCount = 13;
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message straight after reset
    {8'hFF, 1'b0, 1'b0, 1'b0, 256'h0},       // idle item, all data bits set
    {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // "abc", last byte carried on the last item
    {8'hFF, 1'b1, 1'b1, 1'b0, 256'h0},       // single all-ones byte
    {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},       // all-zeros byte
    {8'hA5, 1'b0, 1'b0, 1'b0, 256'h0},       // idle item inside a message
    {8'hFF, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h3C, 1'b0, 1'b1, 1'b0, 256'h0},       // message ended without a byte
    {8'hA5, 1'b0, 1'b1, 1'b1, EmptyDigest},  // ignored data on an empty message
    {8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h7F, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  localparam int BoundaryLens [4] = '{55, 56, 63, 64};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    msg_valid = 1'b0;
  logic                    msg_stall;
  sha256sh_pkg::in_item_t  msg = '0;
  logic                    dgst_valid;
  logic                    dgst_stall = 1'b0;
  sha256sh_pkg::out_item_t dgst;

  // Predictor state: chaining words, block bytes, byte count and overflow flag.
  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_bytes;
  logic        msg_too_long;

  sha256sh_pkg::out_item_t digest_words_due [$];
  sha256sh_pkg::out_item_t due_word;
  int        mismatches = 0;
  int        items_taken = 0;
  int        sink_wait = 0;
  int        calm_left [2] = '{0, 0};

  sha256_stream_hasher i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dgst_valid(dgst_valid),
    .dgst_stall(dgst_stall),
    .dgst      (dgst)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Waiting cycles per transfer, with occasional runs of back-to-back transfers.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(8, 40);
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = InitHash[i];
    msg_bytes    = '0;
    msg_too_long = 1'b0;
  endfunction

  // Sixty-four rounds over the current block bytes, folded into the chaining words.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, x15, x2;
    int t;
    for (t = 0; t < 8; t++) v[t] = chain_h[t];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end else begin
        x15 = w[(t - 15) % 16];
        x2  = w[(t - 2) % 16];
        wt  = w[t % 16] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) +
              w[(t - 7) % 16] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
      end
      w[t % 16] = wt;
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
  endfunction

  // Takes one accepted item; a last item pads, compresses and queues the eight digest words.
  // Where the digest is known in advance it replaces the computed one.
  function automatic void predict_digest(input sha256sh_pkg::in_item_t item, input logic known,
                                         input logic [255:0] fixed_dgst);
    logic [5:0]              fill;
    logic [63:0]             bit_len;
    sha256sh_pkg::out_item_t word;
    int i;
    if (item.byte_valid) begin
      if (msg_bytes == {61{1'b1}}) begin
        msg_too_long = 1'b1;
      end else begin
        block_bytes[msg_bytes[5:0]] = item.data_byte;
        msg_bytes = msg_bytes + 1'b1;
        if (msg_bytes[5:0] == 6'd0) compress_block();
      end
    end
    if (item.last_item) begin
      fill = msg_bytes[5:0];
      block_bytes[fill] = sha256sh_pkg::PadByte;
      for (i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room for the length field: the padding spills into a second block.
      if (fill > sha256sh_pkg::LastPadPos) begin
        compress_block();
        for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      bit_len = {msg_bytes, 3'b000};
      for (i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
      compress_block();
      for (i = 0; i < 8; i++) begin
        word.digest_word  = known ? fixed_dgst[255 - 32*i -: 32] : chain_h[i];
        word.word_index   = i[2:0];
        word.last_word    = (i[2:0] == sha256sh_pkg::LastWord);
        word.length_error = msg_too_long;
        digest_words_due.push_back(word);
      end
      restart_message();
    end
  endfunction

  // Offers one item after a random gap and holds it until the transfer completes.
  // Valid stays high across back-to-back transfers.
  task automatic send_item(input sha256sh_pkg::in_item_t item, input logic known,
                           input logic [255:0] fixed_dgst);
    int gap;
    gap = draw_wait(SideSend);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= item;
    do @(posedge clk); while (msg_stall);
    predict_digest(item, known, fixed_dgst);
    items_taken++;
  endtask

  // A message of random bytes with the odd idle item mixed in; the end is either
  // carried on the final byte or sent as a separate item without a byte.
  task automatic send_message(input int len);
    sha256sh_pkg::in_item_t it;
    logic                   fold;
    int i;
    fold = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        it.data_byte  = 8'($urandom_range(0, 255));
        it.byte_valid = 1'b0;
        it.last_item  = 1'b0;
        send_item(it, 1'b0, '0);
      end
      it.data_byte  = 8'($urandom_range(0, 255));
      it.byte_valid = 1'b1;
      it.last_item  = fold && (i == len - 1);
      send_item(it, 1'b0, '0);
    end
    if (!fold) begin
      it.data_byte  = 8'($urandom_range(0, 255));
      it.byte_valid = 1'b0;
      it.last_item  = 1'b1;
      send_item(it, 1'b0, '0);
    end
  endtask

  // Digest side: check each transfer against the oldest expected word, then stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (dgst_valid && !dgst_stall) begin
        if (digest_words_due.size() == 0) begin
          $display("%0t: unexpected digest word, expected none, got %h index %0d",
                   $time, dgst.digest_word, dgst.word_index);
          mismatches++;
        end else begin
          due_word = digest_words_due.pop_front();
          if (dgst.digest_word !== due_word.digest_word) begin
            $display("%0t: word %0d digest_word expected %h, got %h", $time,
                     due_word.word_index, due_word.digest_word, dgst.digest_word);
            mismatches++;
          end
          if (dgst.word_index !== due_word.word_index) begin
            $display("%0t: word_index expected %0d, got %0d", $time,
                     due_word.word_index, dgst.word_index);
            mismatches++;
          end
          if (dgst.last_word !== due_word.last_word) begin
            $display("%0t: word %0d last_word expected %b, got %b", $time,
                     due_word.word_index, due_word.last_word, dgst.last_word);
            mismatches++;
          end
          if (dgst.length_error !== due_word.length_error) begin
            $display("%0t: word %0d length_error expected %b, got %b", $time,
                     due_word.word_index, due_word.length_error, dgst.length_error);
            mismatches++;
          end
        end
        sink_wait = draw_wait(SideRecv);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      dgst_stall <= (sink_wait != 0);
    end
  end

  // Reset, directed table, messages at the padding boundaries, then random messages.
  initial begin : stimulus
    int r;
    int len;
    restart_message();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (r = 0; r < DirectedCount; r++) begin
      send_item(DirectedRows[r].item, DirectedRows[r].known, DirectedRows[r].dgst);
    end
    for (r = 0; r < 4; r++) send_message(BoundaryLens[r]);
    while (items_taken < TotalItems) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 24);
      send_message(len);
    end
    msg_valid <= 1'b0;
    while (digest_words_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
